### hdl/cgi_dfr_pkg.sv
package cgi_dfr_pkg;

	localparam int unsigned HeaderBytes = 8;
	localparam int unsigned HdrCountW = $clog2(HeaderBytes);

	// Header byte positions that carry fields we keep, and the last header byte
	localparam logic [HdrCountW-1:0] HdrPosType    = HdrCountW'(1);
	localparam logic [HdrCountW-1:0] HdrPosLenHigh = HdrCountW'(4);
	localparam logic [HdrCountW-1:0] HdrPosLenLow  = HdrCountW'(5);
	localparam logic [HdrCountW-1:0] HdrPosPadLen  = HdrCountW'(6);
	localparam logic [HdrCountW-1:0] HdrPosLast    = HdrCountW'(HeaderBytes - 1);

	// Record types
	localparam logic [7:0] TypeEndRequest = 8'd3;
	localparam logic [7:0] TypeStdout     = 8'd6;
	localparam logic [7:0] TypeStderr     = 8'd7;

	typedef enum logic [1:0] {
		KIND_STDOUT    = 2'd0,
		KIND_STDERR    = 2'd1,
		KIND_REQ_ENDED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_CONTENT = 2'd1,
		PH_PADDING = 2'd2
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		kind_t      stream_kind;
		logic       last_in_record;
	} result_t;

endpackage

### hdl/cgi_dfr_core.sv
module cgi_dfr_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            in_byte,
	output cgi_dfr_pkg::result_t  result
);

	cgi_dfr_pkg::phase_t                    phase_q, phase_d;
	logic [cgi_dfr_pkg::HdrCountW-1:0]      hdr_count_q, hdr_count_d;
	logic [7:0]                             rec_type_q, rec_type_d;
	logic [15:0]                            content_q, content_d;
	logic [7:0]                             padding_q, padding_d;
	logic [7:0]                             len_high_q, len_high_d;

	logic [15:0] content_dec;
	logic [7:0]  padding_dec;
	logic        is_stream;
	logic        is_end_req;

	assign content_dec = content_q - 16'd1;
	assign padding_dec = padding_q - 8'd1;
	assign is_stream   = (rec_type_q == cgi_dfr_pkg::TypeStdout) ||
	                     (rec_type_q == cgi_dfr_pkg::TypeStderr);
	assign is_end_req  = (rec_type_q == cgi_dfr_pkg::TypeEndRequest);

	// Next state: header collection, content and padding countdown
	always_comb begin
		phase_d     = phase_q;
		hdr_count_d = hdr_count_q;
		rec_type_d  = rec_type_q;
		content_d   = content_q;
		padding_d   = padding_q;
		len_high_d  = len_high_q;
		unique case (phase_q)
			cgi_dfr_pkg::PH_CONTENT: begin
				content_d = content_dec;
				if (content_dec == 16'd0) begin
					phase_d = (padding_q != 8'd0) ? cgi_dfr_pkg::PH_PADDING
					                               : cgi_dfr_pkg::PH_HEADER;
				end
			end
			cgi_dfr_pkg::PH_PADDING: begin
				padding_d = padding_dec;
				if (padding_dec == 8'd0) begin
					phase_d = cgi_dfr_pkg::PH_HEADER;
				end
			end
			default: begin
				phase_d = cgi_dfr_pkg::PH_HEADER;
				case (hdr_count_q)
					cgi_dfr_pkg::HdrPosType:    rec_type_d = in_byte;
					cgi_dfr_pkg::HdrPosLenHigh: len_high_d = in_byte;
					cgi_dfr_pkg::HdrPosLenLow:  content_d  = {len_high_q, in_byte};
					cgi_dfr_pkg::HdrPosPadLen:  padding_d  = in_byte;
					default: ;
				endcase
				if (hdr_count_q == cgi_dfr_pkg::HdrPosLast) begin
					hdr_count_d = '0;
					if (content_q != 16'd0) begin
						phase_d = cgi_dfr_pkg::PH_CONTENT;
					end else if (padding_q != 8'd0) begin
						phase_d = cgi_dfr_pkg::PH_PADDING;
					end
				end else begin
					hdr_count_d = hdr_count_q + cgi_dfr_pkg::HdrCountW'(1);
				end
			end
		endcase
	end

	// Result for the current item: content byte or request-ended marker
	always_comb begin
		result                = '0;
		result.data_byte      = 8'd0;
		result.stream_kind    = cgi_dfr_pkg::KIND_REQ_ENDED;
		result.last_in_record = 1'b1;
		unique case (phase_q)
			cgi_dfr_pkg::PH_CONTENT: begin
				if (is_stream) begin
					result.valid          = 1'b1;
					result.data_byte      = in_byte;
					result.stream_kind    = (rec_type_q == cgi_dfr_pkg::TypeStdout) ?
					                        cgi_dfr_pkg::KIND_STDOUT :
					                        cgi_dfr_pkg::KIND_STDERR;
					result.last_in_record = (content_dec == 16'd0);
				end else begin
					result.valid = is_end_req && (content_dec == 16'd0) &&
					               (padding_q == 8'd0);
				end
			end
			cgi_dfr_pkg::PH_PADDING: begin
				result.valid = is_end_req && (padding_dec == 8'd0);
			end
			default: begin
				result.valid = is_end_req && (hdr_count_q == cgi_dfr_pkg::HdrPosLast) &&
				               (content_q == 16'd0) && (padding_q == 8'd0);
			end
		endcase
	end

	// Advance state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cgi_dfr_pkg::PH_HEADER;
			hdr_count_q <= '0;
			rec_type_q  <= 8'd0;
			content_q   <= 16'd0;
			padding_q   <= 8'd0;
			len_high_q  <= 8'd0;
		end else if (advance) begin
			phase_q     <= phase_d;
			hdr_count_q <= hdr_count_d;
			rec_type_q  <= rec_type_d;
			content_q   <= content_d;
			padding_q   <= padding_d;
			len_high_q  <= len_high_d;
		end
	end

endmodule

### hdl/cgi_record_stream_deframer.sv
// Channel   Dir  tdata                 tuser               tlast
// s_axis    in   [7:0] in_byte         -                   -
// m_axis    out  [7:0] data_byte       [1:0] stream_kind   last_in_record
//
// One byte item is accepted per clock; each item gives zero or one result item.
// The result appears in the output register in the cycle after its input item.
// Input is taken whenever the output register is empty or being drained, so a
// stall on the output side holds the input side only while a result waits.
// Reset (arst_n low) returns to header collection with all counters cleared.
module cgi_record_stream_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [1:0] m_tuser,   // [1:0] stream_kind
	output logic       m_tlast    // last_in_record
);

	cgi_dfr_pkg::result_t result;
	logic                 accept;
	logic                 out_valid_q;
	logic [7:0]           out_data_q;
	logic [1:0]           out_kind_q;
	logic                 out_last_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	cgi_dfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.in_byte (s_tdata),
		.result  (result)
	);

	// Load the result register; clear it once the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= result.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result.data_byte;
			out_kind_q <= result.stream_kind;
			out_last_q <= result.last_in_record;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

### dv/tb_top.sv
module tb_top;

	// Cycles without any accepted item before the run is declared hung
	localparam int unsigned StallLimit = 2000;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	// Idle enables for the sender and the receiver, changed per phase
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int unsigned sent_bytes = 0;
	int unsigned quiet_cycles = 0;

	typedef struct {
		logic [7:0]          data_byte;
		cgi_dfr_pkg::kind_t  stream_kind;
		logic                last_in_record;
	} deframed_item_t;

	// Tracks record framing on accepted bytes and holds the items the block owes
	class deframe_scoreboard;
		cgi_dfr_pkg::phase_t                ph;
		logic [cgi_dfr_pkg::HdrCountW-1:0]  hdr_pos;
		logic [7:0]                         rec_type;
		logic [15:0]                        content_left;
		logic [7:0]                         pad_left;
		logic [7:0]                         len_high;
		deframed_item_t                     expected_items[$];
		int unsigned                        mismatches;

		function new();
			ph = cgi_dfr_pkg::PH_HEADER;
			hdr_pos = '0;
			rec_type = 8'h00;
			content_left = 16'h0000;
			pad_left = 8'h00;
			len_high = 8'h00;
			mismatches = 0;
		endfunction

		function int unsigned pending();
			return expected_items.size();
		endfunction

		// Return to header collection; an end-request record reports its end
		function void close_record();
			deframed_item_t it;
			ph = cgi_dfr_pkg::PH_HEADER;
			if (rec_type == cgi_dfr_pkg::TypeEndRequest) begin
				it.data_byte = 8'h00;
				it.stream_kind = cgi_dfr_pkg::KIND_REQ_ENDED;
				it.last_in_record = 1'b1;
				expected_items.push_back(it);
			end
		endfunction

		function void note_byte(logic [7:0] b);
			deframed_item_t it;
			bit passed;
			case (ph)
				cgi_dfr_pkg::PH_CONTENT: begin
					passed = 1'b0;
					content_left = content_left - 16'd1;
					if (rec_type == cgi_dfr_pkg::TypeStdout ||
					    rec_type == cgi_dfr_pkg::TypeStderr) begin
						it.data_byte = b;
						it.stream_kind = (rec_type == cgi_dfr_pkg::TypeStdout) ?
						                 cgi_dfr_pkg::KIND_STDOUT : cgi_dfr_pkg::KIND_STDERR;
						it.last_in_record = (content_left == 16'd0);
						expected_items.push_back(it);
						passed = 1'b1;
					end
					if (content_left == 16'd0) begin
						if (pad_left != 8'd0)
							ph = cgi_dfr_pkg::PH_PADDING;
						else if (!passed)
							close_record();
						else
							ph = cgi_dfr_pkg::PH_HEADER;
					end
				end
				cgi_dfr_pkg::PH_PADDING: begin
					pad_left = pad_left - 8'd1;
					if (pad_left == 8'd0)
						close_record();
				end
				default: begin
					// Header bytes; an unused phase value is treated the same way
					ph = cgi_dfr_pkg::PH_HEADER;
					case (hdr_pos)
						cgi_dfr_pkg::HdrPosType:    rec_type = b;
						cgi_dfr_pkg::HdrPosLenHigh: len_high = b;
						cgi_dfr_pkg::HdrPosLenLow:  content_left = {len_high, b};
						cgi_dfr_pkg::HdrPosPadLen:  pad_left = b;
						default: ;
					endcase
					if (hdr_pos == cgi_dfr_pkg::HdrPosLast) begin
						hdr_pos = '0;
						if (content_left != 16'd0)
							ph = cgi_dfr_pkg::PH_CONTENT;
						else if (pad_left != 8'd0)
							ph = cgi_dfr_pkg::PH_PADDING;
						else
							close_record();
					end else begin
						hdr_pos = hdr_pos + cgi_dfr_pkg::HdrCountW'(1);
					end
				end
			endcase
		endfunction

		function void check_item(logic [7:0] d, logic [1:0] k, logic l);
			deframed_item_t want;
			if (expected_items.size() == 0) begin
				$error("result item with none expected: data_byte %0h stream_kind %0d last %0b",
					d, k, l);
				mismatches++;
				return;
			end
			want = expected_items.pop_front();
			if (d !== want.data_byte) begin
				$error("data_byte: expected %0h, got %0h", want.data_byte, d);
				mismatches++;
			end
			if (k !== want.stream_kind) begin
				$error("stream_kind: expected %0d, got %0d", want.stream_kind, k);
				mismatches++;
			end
			if (l !== want.last_in_record) begin
				$error("last_in_record: expected %0b, got %0b", want.last_in_record, l);
				mismatches++;
			end
		endfunction
	endclass

	deframe_scoreboard board = new();

	cgi_record_stream_deframer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Check every result item taken by the receiver
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_item(m_tdata, m_tuser, m_tlast);
	end

	// Abort when nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Receiver: stall at random while rx_idle is set, hold ready for short bursts
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = rx_idle ? pick_gap() : 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = tx_idle ? pick_gap() : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		board.note_byte(b);
		sent_bytes++;
	endtask

	// Header with random version, request id and reserved byte, then body and padding
	task automatic send_record(input logic [7:0] rtype, input logic [15:0] clen,
			input logic [7:0] plen);
		send_byte(8'($urandom));
		send_byte(rtype);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		send_byte(clen[15:8]);
		send_byte(clen[7:0]);
		send_byte(plen);
		send_byte(8'($urandom));
		repeat (clen) send_byte(8'($urandom));
		repeat (plen) send_byte(8'($urandom));
	endtask

	// Hold the sender until every owed result item has been taken
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_type();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return cgi_dfr_pkg::TypeStdout;
		if (r < 60)
			return cgi_dfr_pkg::TypeStderr;
		if (r < 75)
			return cgi_dfr_pkg::TypeEndRequest;
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_content_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 16'd0;
		if (r < 94)
			return 16'($urandom_range(1, 8));
		return 16'($urandom_range(9, 300));
	endfunction

	function automatic logic [7:0] pick_pad_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 8'd0;
		if (r < 95)
			return 8'($urandom_range(1, 7));
		return 8'($urandom_range(8, 255));
	endfunction

	initial begin
		int unsigned phase_idx;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: single-byte content, both streams, end-request ending on
		// each kind of byte, unknown types, zero-length records
		send_record(cgi_dfr_pkg::TypeStdout, 16'd1, 8'd0);
		send_record(cgi_dfr_pkg::TypeStderr, 16'd3, 8'd2);
		send_record(cgi_dfr_pkg::TypeEndRequest, 16'd0, 8'd0);
		send_record(cgi_dfr_pkg::TypeEndRequest, 16'd0, 8'd3);
		send_record(cgi_dfr_pkg::TypeEndRequest, 16'd2, 8'd0);
		send_record(cgi_dfr_pkg::TypeEndRequest, 16'd2, 8'd1);
		send_record(8'h00, 16'd2, 8'd1);
		send_record(8'hFF, 16'd1, 8'd0);
		send_record(cgi_dfr_pkg::TypeStdout, 16'd0, 8'd2);
		send_record(cgi_dfr_pkg::TypeStderr, 16'd0, 8'd0);
		drain_results();

		// Random records across idle settings
		phase_idx = 0;
		while (sent_bytes < 560) begin
			tx_idle = (phase_idx % 3) != 2;
			rx_idle = (phase_idx % 4) != 3;
			repeat (6) send_record(pick_type(), pick_content_len(), pick_pad_len());
			if (phase_idx == 2)
				drain_results();
			phase_idx++;
		end

		// Record whose length needs the high length byte, without idling
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_record(cgi_dfr_pkg::TypeStdout, 16'h0102, 8'h05);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_record(cgi_dfr_pkg::TypeEndRequest, 16'd1, 8'd1);

		drain_results();
		repeat (4) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

### cgi_record_stream_deframer.f
hdl/cgi_dfr_pkg.sv
hdl/cgi_dfr_core.sv
hdl/cgi_record_stream_deframer.sv
dv/tb_top.sv
